// File: sv/krv_pkg.sv
// Shared constants, types and code-range helpers for the key-slot report validator.
`timescale 1ns / 1ps
`default_nettype none

package krv_pkg;

    // Report layout
    localparam int unsigned RPT_LEN      = 64;
    localparam int unsigned TRIPLE_START = 9;
    localparam int unsigned TRIPLE_END   = 60;
    localparam int unsigned TRIPLE_COUNT = 17;
    localparam int unsigned MAX_KEYS     = 5;
    localparam int unsigned SLOT_LIMIT   = 25;

    // Field widths
    localparam int unsigned POS_W   = 7;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned CODE_W  = 8;

    // Header and triple byte values
    localparam logic [7:0] HDR_REPORT_ID = 8'h03;
    localparam logic [7:0] HDR_COMMAND   = 8'hfa;
    localparam logic [7:0] HDR_ONE       = 8'h01;
    localparam logic [7:0] TRIPLE_FLAG   = 8'h32;

    // Modifier code range
    localparam logic [7:0] MOD_FIRST = 8'hf1;
    localparam logic [7:0] MOD_LAST  = 8'hf4;

    typedef logic [MAX_KEYS-1:0][CODE_W-1:0] t_code_bank;

    // Verdict of one key code against the codes seen so far
    typedef struct packed {
        logic pass;          // code satisfies every key rule
        logic store;         // record the code in the bank
        logic take_regular;  // code uses up the single non-modifier key
    } t_code_res;

    function automatic logic is_modifier(input logic [7:0] c);
        return (c >= MOD_FIRST) && (c <= MOD_LAST);
    endfunction

    function automatic logic regular_allowed(input logic [7:0] c);
        return ((c >= 8'h04) && (c <= 8'h31)) ||
               ((c >= 8'h33) && (c <= 8'h57)) ||
               ((c >= 8'h59) && (c <= 8'h63)) ||
               (c == 8'h65) ||
               ((c >= 8'h68) && (c <= 8'h73));
    endfunction

endpackage

`default_nettype wire

// File: sv/krv_code_check.sv
// Key code rules: count limit, lone zero key, repeats, modifiers and regular key ranges.
`timescale 1ns / 1ps
`default_nettype none

module krv_code_check (
    input  wire logic [7:0]                    i_code,
    input  wire logic [krv_pkg::IDX_W-1:0]     i_idx,
    input  wire logic [krv_pkg::COUNT_W-1:0]   i_key_count,
    input  wire krv_pkg::t_code_bank           i_bank,
    input  wire logic                          i_regular_taken,
    output krv_pkg::t_code_res                 o_res
);
    import krv_pkg::*;

    logic dup;

    always_comb begin
        dup = 1'b0;
        for (int k = 0; k < int'(MAX_KEYS); k++) begin
            if ((i_idx > IDX_W'(k)) && (i_bank[k] == i_code)) begin
                dup = 1'b1;
            end
        end
    end

    always_comb begin
        o_res = '0;
        priority if (i_idx >= IDX_W'(i_key_count)) begin
            // past the count: slot must be empty
            o_res.pass = (i_code == 8'h00);
        end else if (i_code == 8'h00) begin
            o_res.pass = (i_key_count == COUNT_W'(1)) && (i_idx == '0);
        end else if (dup) begin
            o_res.pass = 1'b0;
        end else if (is_modifier(i_code)) begin
            o_res.store = 1'b1;
            o_res.pass  = 1'b1;
        end else if (!regular_allowed(i_code) || i_regular_taken) begin
            o_res.store = 1'b1;
            o_res.pass  = 1'b0;
        end else begin
            o_res.store        = 1'b1;
            o_res.pass         = 1'b1;
            o_res.take_regular = 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: sv/keymap_report_validator.sv
// Top level of the key-slot report validator: input register, byte checks, verdict register.
`timescale 1ns / 1ps
`default_nettype none

// Checks a 64-byte key-slot report fed from byte zero, one item (byte) per clock
// while the input does not stall, against the layer and slot it is meant for.
// Each accepted byte is held in an input register, checked against a handful of
// per-report registers (byte position, fault flag, key count, triple counters, a
// bank of five key codes) and then retired; a new byte is accepted as the held
// one retires, so the sustained rate is one byte per clock unless stalled. Only
// the byte marked last yields a result item: o_report_ok is 1 when the report
// was exactly 64 bytes long and every check passed. The verdict waits in an
// output register; the input side stalls only when a last byte is held while an
// earlier verdict is still stalled downstream. After a last byte all per-report
// state starts over.
module keymap_report_validator (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // report byte channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [1:0] i_target_layer,
    input  wire logic [4:0] i_target_slot,
    input  wire logic       i_last_byte,
    // verdict channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_report_ok
);
    import krv_pkg::*;

    // input register
    logic                 r_in_valid;
    logic [7:0]           r_in_data;
    logic [1:0]           r_in_layer;
    logic [4:0]           r_in_slot;
    logic                 r_in_last;

    // per-report state
    logic [POS_W-1:0]     r_pos;
    logic                 r_fault;
    logic [COUNT_W-1:0]   r_key_count;
    logic [IDX_W-1:0]     r_idx;
    logic [1:0]           r_part;
    logic                 r_regular_taken;
    t_code_bank           r_codes;

    // verdict register
    logic                 r_out_valid;
    logic                 r_out_ok;

    logic                 accept;
    logic                 advance;
    logic                 in_triples;
    logic                 code_byte;
    logic                 byte_ok;
    logic                 count_ok;
    logic                 target_ok;
    logic                 n_fault;
    logic [POS_W-1:0]     n_pos;
    t_code_res            code_res;

    // Retire the held byte unless it is a last byte and the verdict slot is blocked.
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    assign in_triples = (r_pos >= POS_W'(TRIPLE_START)) && (r_pos < POS_W'(TRIPLE_END));
    assign code_byte  = in_triples && (r_part == 2'd0);
    assign count_ok   = (r_in_data >= 8'd1) && (r_in_data <= 8'(MAX_KEYS));
    assign target_ok  = (r_in_layer != 2'd0) && (r_in_slot != 5'd0) &&
                        (r_in_slot <= 5'(SLOT_LIMIT));

    krv_code_check u_code_check (
        .i_code          (r_in_data),
        .i_idx           (r_idx),
        .i_key_count     (r_key_count),
        .i_bank          (r_codes),
        .i_regular_taken (r_regular_taken),
        .o_res           (code_res)
    );

    // Byte check by position in the report.
    always_comb begin
        priority if (r_pos >= POS_W'(RPT_LEN)) begin
            byte_ok = 1'b0;
        end else if (r_pos == POS_W'(0)) begin
            byte_ok = (r_in_data == HDR_REPORT_ID);
        end else if (r_pos == POS_W'(1)) begin
            byte_ok = (r_in_data == HDR_COMMAND);
        end else if (r_pos == POS_W'(2)) begin
            byte_ok = (r_in_data == {3'b000, r_in_slot});
        end else if (r_pos == POS_W'(3)) begin
            byte_ok = (r_in_data == {6'b000000, r_in_layer});
        end else if (r_pos == POS_W'(4)) begin
            byte_ok = (r_in_data == HDR_ONE);
        end else if (r_pos == POS_W'(5)) begin
            byte_ok = (r_in_data <= HDR_ONE);
        end else if (r_pos == POS_W'(6)) begin
            byte_ok = count_ok;
        end else if (in_triples) begin
            unique case (r_part)
                2'd0:    byte_ok = code_res.pass;
                2'd1:    byte_ok = (r_in_data == 8'h00);
                default: byte_ok = (r_in_data == 8'h00) || (r_in_data == TRIPLE_FLAG);
            endcase
        end else begin
            // header padding bytes and the trailing four bytes
            byte_ok = (r_in_data == 8'h00);
        end
    end

    assign n_fault = r_fault || !byte_ok || !target_ok;
    assign n_pos   = (r_pos < POS_W'(RPT_LEN)) ? r_pos + POS_W'(1) : r_pos;

    // Input register: load on accept, drop once retired.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_data  <= i_data_byte;
            r_in_layer <= i_target_layer;
            r_in_slot  <= i_target_slot;
            r_in_last  <= i_last_byte;
        end
    end

    // Per-report state: advance on each retired byte, start over after a last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos           <= '0;
            r_fault         <= 1'b0;
            r_key_count     <= '0;
            r_idx           <= '0;
            r_part          <= '0;
            r_regular_taken <= 1'b0;
        end else if (advance) begin
            if (r_in_last) begin
                r_pos           <= '0;
                r_fault         <= 1'b0;
                r_key_count     <= '0;
                r_idx           <= '0;
                r_part          <= '0;
                r_regular_taken <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_fault <= n_fault;
                if (r_pos == POS_W'(6)) begin
                    r_key_count <= count_ok ? r_in_data[COUNT_W-1:0] : '0;
                end
                if (in_triples) begin
                    if (r_part == 2'd2) begin
                        r_part <= 2'd0;
                        r_idx  <= r_idx + IDX_W'(1);
                    end else begin
                        r_part <= r_part + 2'd1;
                    end
                end
                if (code_byte && code_res.take_regular) begin
                    r_regular_taken <= 1'b1;
                end
            end
        end
    end

    // Key code bank: written in count order, read only below the current index.
    always_ff @(posedge i_clk) begin
        if (advance && code_byte && code_res.store) begin
            r_codes[r_idx[2:0]] <= r_in_data;
        end
    end

    // Verdict register: hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_ok <= !n_fault && (r_pos == POS_W'(RPT_LEN - 1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_report_ok = r_out_ok;

    // A held byte is only ever blocked by a waiting verdict.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_last && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked verdict");

    // Byte position never passes the report length.
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(RPT_LEN))
        else $error("byte position beyond report length");

    // A retired last byte leaves a clean report state and a pending verdict.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_pos == '0 && !r_fault && !r_regular_taken &&
                                    r_out_valid))
        else $error("report state not cleared after last byte");

    // Key count is always within the allowed range.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= COUNT_W'(MAX_KEYS))
        else $error("key count out of range");

endmodule

`default_nettype wire

// File: sim/keymap_report_validator_tb.sv
// Self-checking testbench for the key-slot report validator: directed and random reports.
`timescale 1ns / 1ps

module keymap_report_validator_tb;
    import krv_pkg::*;

    localparam int BUF_BYTES          = 72;    // longest report the generator builds, plus margin
    localparam int TOTAL_BYTES        = 1450;  // items over the whole run, directed part included
    localparam int MIN_RANDOM_REPORTS = 6;
    localparam int QUIET_BYTES        = 200;   // closing stretch of the run with no idling
    localparam int MAX_SHOWN          = 10;

    // Ways to build one report: well-formed ones first, then one flaw per kind, then raw noise
    typedef enum logic [4:0] {
        RK_GOOD,
        RK_ALL_MODS,
        RK_ZERO_SOLE,
        RK_HEADER,
        RK_COUNT,
        RK_PAD,
        RK_MID,
        RK_FLAG,
        RK_EXTRA_CODE,
        RK_ZERO_CODE,
        RK_DUP,
        RK_TWO_REGULAR,
        RK_BAD_REGULAR,
        RK_TAIL,
        RK_SHORT,
        RK_LONG,
        RK_TARGET,
        RK_NOISE
    } t_rpt_kind;

    // Where the expected verdict of a report comes from
    typedef enum logic [1:0] {
        V_FAIL,
        V_PASS,
        V_PREDICT
    } t_verdict_src;

    typedef struct packed {
        t_rpt_kind    kind;
        logic [1:0]   lay;
        logic [4:0]   slt;
        logic [2:0]   keys;   // 0: pick the key count at random
        logic [7:0]   arg;    // selects the byte or variant of the flaw
        t_verdict_src pin;
    } t_case;

    // Directed reports: one row per report, walked in order
    localparam t_case DIRECTED [0:18] = '{
        '{RK_GOOD,        2'd3, 5'd25, 3'd5, 8'd0,   V_PASS},     // top layer, top slot, full
        '{RK_GOOD,        2'd1, 5'd1,  3'd1, 8'd0,   V_PASS},     // bottom layer and slot
        '{RK_ALL_MODS,    2'd2, 5'd13, 3'd4, 8'd0,   V_PASS},     // every modifier at once
        '{RK_ZERO_SOLE,   2'd1, 5'd7,  3'd1, 8'd0,   V_PASS},     // zero code as the sole key
        '{RK_HEADER,      2'd2, 5'd3,  3'd2, 8'd0,   V_FAIL},     // report id
        '{RK_HEADER,      2'd2, 5'd3,  3'd2, 8'd5,   V_FAIL},     // byte five above one
        '{RK_COUNT,       2'd1, 5'd9,  3'd0, 8'd0,   V_FAIL},     // key count zero
        '{RK_COUNT,       2'd1, 5'd9,  3'd0, 8'd1,   V_FAIL},     // key count six
        '{RK_EXTRA_CODE,  2'd2, 5'd20, 3'd2, 8'd0,   V_FAIL},     // code past the count
        '{RK_ZERO_CODE,   2'd2, 5'd20, 3'd3, 8'd0,   V_FAIL},     // zero code among others
        '{RK_DUP,         2'd2, 5'd20, 3'd5, 8'd0,   V_FAIL},
        '{RK_TWO_REGULAR, 2'd1, 5'd11, 3'd2, 8'd0,   V_FAIL},
        '{RK_BAD_REGULAR, 2'd1, 5'd11, 3'd1, 8'd0,   V_FAIL},
        '{RK_SHORT,       2'd2, 5'd5,  3'd2, 8'd62,  V_FAIL},     // one byte short
        '{RK_SHORT,       2'd2, 5'd5,  3'd2, 8'd0,   V_FAIL},     // single byte
        '{RK_LONG,        2'd2, 5'd5,  3'd2, 8'd0,   V_FAIL},     // one byte long
        '{RK_GOOD,        2'd3, 5'd31, 3'd2, 8'd0,   V_FAIL},     // slot above the limit
        '{RK_TARGET,      2'd2, 5'd6,  3'd2, 8'd104, V_FAIL},     // slot drops to zero mid-report
        '{RK_NOISE,       2'd0, 5'd0,  3'd0, 8'd0,   V_PREDICT}
    };

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [7:0] i_data_byte    = 8'h00;
    logic [1:0] i_target_layer = 2'd0;
    logic [4:0] i_target_slot  = 5'd0;
    logic       i_last_byte    = 1'b0;
    logic       i_out_stall    = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_report_ok;

    keymap_report_validator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_target_layer (i_target_layer),
        .i_target_slot  (i_target_slot),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_report_ok    (o_report_ok)
    );

    // Validator state as this testbench sees it
    int unsigned pos_r;
    bit          fault_r;
    int unsigned keys_r;
    logic [7:0]  bank_r [0:MAX_KEYS-1];
    bit          plain_used_r;

    bit           verdict_q [$];          // verdicts still owed by the block, oldest first
    t_verdict_src verdict_pin = V_PREDICT;

    // Report under construction, one entry per byte
    logic [7:0] rpt_data [0:BUF_BYTES-1];
    logic [1:0] rpt_lay  [0:BUF_BYTES-1];
    logic [4:0] rpt_slt  [0:BUF_BYTES-1];
    int         rpt_len;

    int bytes_sent;
    int reports_sent;
    bit gaps_on;
    int stall_left;
    int mismatches;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Key code rules
    // ---------------------------------------------------------------------

    function automatic bit plain_code(input logic [7:0] c);
        return (c >= 8'h04 && c <= 8'h31) || (c >= 8'h33 && c <= 8'h57) ||
               (c >= 8'h59 && c <= 8'h63) || c == 8'h65 ||
               (c >= 8'h68 && c <= 8'h73);
    endfunction

    function automatic bit modifier_code(input logic [7:0] c);
        return c >= MOD_FIRST && c <= MOD_LAST;
    endfunction

    // Judge the key code of triple idx, and record it in the bank when it is in the count, non-zero and no repeat
    function automatic bit key_code_ok(input logic [7:0] c, input int unsigned idx);
        if (idx >= keys_r)
            return c == 8'h00;
        if (c == 8'h00)
            return keys_r == 1 && idx == 0;
        for (int k = 0; k < idx; k++)
            if (bank_r[k] == c)
                return 1'b0;
        bank_r[idx] = c;
        if (modifier_code(c))
            return 1'b1;
        if (!plain_code(c) || plain_used_r)
            return 1'b0;
        plain_used_r = 1'b1;
        return 1'b1;
    endfunction

    task automatic clear_report_state();
        pos_r        = 0;
        fault_r      = 1'b0;
        keys_r       = 0;
        plain_used_r = 1'b0;
    endtask

    // Advance the predicted state by one accepted item; owe a verdict on a last byte
    task automatic take_byte(input logic [7:0] b, input logic [1:0] lay, input logic [4:0] slt,
                             input bit last);
        int unsigned p;
        int unsigned rel;
        bit          ok;
        p  = pos_r;
        ok = lay != 2'd0 && slt != 5'd0 && slt <= SLOT_LIMIT;
        if (p >= RPT_LEN) begin
            ok = 1'b0;
        end else if (p == 0) begin
            ok = ok && b == HDR_REPORT_ID;
        end else if (p == 1) begin
            ok = ok && b == HDR_COMMAND;
        end else if (p == 2) begin
            ok = ok && b == {3'b000, slt};
        end else if (p == 3) begin
            ok = ok && b == {6'b000000, lay};
        end else if (p == 4) begin
            ok = ok && b == HDR_ONE;
        end else if (p == 5) begin
            ok = ok && b <= 8'h01;
        end else if (p == 6) begin
            // an out-of-range count is held as zero, so every code must then be zero
            if (b >= 8'd1 && b <= MAX_KEYS) begin
                keys_r = b;
            end else begin
                keys_r = 0;
                ok     = 1'b0;
            end
        end else if (p < TRIPLE_START) begin
            ok = ok && b == 8'h00;
        end else if (p < TRIPLE_END) begin
            rel = p - TRIPLE_START;
            case (rel % 3)
                0:       if (!key_code_ok(b, rel / 3)) ok = 1'b0;
                1:       ok = ok && b == 8'h00;
                default: ok = ok && (b == 8'h00 || b == TRIPLE_FLAG);
            endcase
        end else begin
            ok = ok && b == 8'h00;
        end
        if (!ok)
            fault_r = 1'b1;
        if (pos_r < RPT_LEN)
            pos_r++;
        if (last) begin
            if (verdict_pin == V_PREDICT)
                verdict_q.push_back(!fault_r && p == RPT_LEN - 1);
            else
                verdict_q.push_back(verdict_pin == V_PASS);
            clear_report_state();
        end
    endtask

    // ---------------------------------------------------------------------
    // Report generation
    // ---------------------------------------------------------------------

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        c = 8'($urandom_range(8'h04, 8'h73));
        while (!plain_code(c))
            c = 8'($urandom_range(8'h04, 8'h73));
        return c;
    endfunction

    // True when the code of triple idx is zero or repeats an earlier code
    function automatic bit code_taken(input logic [7:0] c, input int idx);
        if (c == 8'h00)
            return 1'b1;
        for (int k = 0; k < idx; k++)
            if (rpt_data[TRIPLE_START + 3 * k] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    // Build a well-formed report with random content, then apply at most one flaw
    task automatic build_report(input t_rpt_kind kind, input logic [1:0] lay,
                                input logic [4:0] slt, input int keys, input int arg);
        logic [7:0] codes [0:MAX_KEYS-1];
        logic [7:0] mods  [0:3];
        logic [7:0] c;
        logic [7:0] t;
        logic [1:0] noise_lay;
        logic [4:0] noise_slt;
        int         k;
        int         nmods;
        int         j;
        int         p;
        int         cnt;

        k = keys != 0 ? keys : int'($urandom_range(1, MAX_KEYS));
        if (kind inside {RK_ZERO_CODE, RK_DUP, RK_TWO_REGULAR} && k < 2)
            k = $urandom_range(2, MAX_KEYS);
        if (kind == RK_ZERO_SOLE)
            k = 1;
        if (kind == RK_ALL_MODS && k > 4)
            k = 4;

        // shuffle the modifiers, take as many as needed, add at most one plain key
        for (int i = 0; i < 4; i++)
            mods[i] = MOD_FIRST + 8'(i);
        for (int i = 3; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = mods[i];
            mods[i] = mods[j];
            mods[j] = t;
        end
        if (kind == RK_ALL_MODS)
            nmods = k;
        else if (k == MAX_KEYS)
            nmods = 4;
        else
            nmods = k - int'($urandom_range(0, 1));
        for (int i = 0; i < k; i++)
            codes[i] = i < nmods ? mods[i] : pick_plain();
        if (k == 1 && nmods == 0 && $urandom_range(0, 3) == 0)
            codes[0] = 8'h00;
        if (kind == RK_ZERO_SOLE)
            codes[0] = 8'h00;
        if (kind == RK_TWO_REGULAR) begin
            codes[0] = pick_plain();
            do
                codes[k-1] = pick_plain();
            while (codes[k-1] == codes[0]);
            for (int i = 1; i < k - 1; i++)
                codes[i] = mods[i-1];
        end
        for (int i = k - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = codes[i];
            codes[i] = codes[j];
            codes[j] = t;
        end

        // lay out the bytes; anything past byte 63 is random filler for long reports
        for (int i = 0; i < BUF_BYTES; i++) begin
            rpt_data[i] = 8'($urandom);
            rpt_lay[i]  = lay;
            rpt_slt[i]  = slt;
        end
        rpt_data[0] = HDR_REPORT_ID;
        rpt_data[1] = HDR_COMMAND;
        rpt_data[2] = {3'b000, slt};
        rpt_data[3] = {6'b000000, lay};
        rpt_data[4] = HDR_ONE;
        rpt_data[5] = 8'($urandom_range(0, 1));
        rpt_data[6] = 8'(k);
        rpt_data[7] = 8'h00;
        rpt_data[8] = 8'h00;
        for (int i = 0; i < TRIPLE_COUNT; i++) begin
            p               = TRIPLE_START + 3 * i;
            rpt_data[p]     = i < k ? codes[i] : 8'h00;
            rpt_data[p + 1] = 8'h00;
            rpt_data[p + 2] = $urandom_range(0, 1) ? TRIPLE_FLAG : 8'h00;
        end
        for (int i = TRIPLE_END; i < RPT_LEN; i++)
            rpt_data[i] = 8'h00;
        rpt_len = RPT_LEN;

        case (kind)
            RK_HEADER: begin
                p = arg % 6;
                if (p == 5)
                    rpt_data[5] = 8'($urandom_range(2, 255));
                else
                    rpt_data[p] = rpt_data[p] + 8'($urandom_range(1, 255));
            end
            RK_COUNT: begin
                case (arg % 3)
                    0:       rpt_data[6] = 8'h00;
                    1:       rpt_data[6] = 8'(MAX_KEYS + 1);
                    default: rpt_data[6] = 8'($urandom_range(MAX_KEYS + 2, 255));
                endcase
            end
            RK_PAD: rpt_data[7 + arg % 2] = 8'($urandom_range(1, 255));
            RK_MID: rpt_data[TRIPLE_START + 1 + 3 * (arg % 17)] = 8'($urandom_range(1, 255));
            RK_FLAG: begin
                do
                    c = 8'($urandom_range(1, 255));
                while (c == TRIPLE_FLAG);
                rpt_data[TRIPLE_START + 2 + 3 * (arg % 17)] = c;
            end
            RK_EXTRA_CODE: begin
                p = k + arg % (TRIPLE_COUNT - k);
                rpt_data[TRIPLE_START + 3 * p] = 8'($urandom_range(1, 255));
            end
            RK_ZERO_CODE: rpt_data[TRIPLE_START + 3 * (k - 1)] = 8'h00;
            RK_DUP: begin
                p = $urandom_range(0, k - 2);
                rpt_data[TRIPLE_START + 3 * (k - 1)] = rpt_data[TRIPLE_START + 3 * p];
            end
            RK_BAD_REGULAR: begin
                do
                    c = 8'($urandom_range(1, 255));
                while (plain_code(c) || modifier_code(c));
                rpt_data[TRIPLE_START + 3 * (k - 1)] = c;
            end
            RK_TAIL: rpt_data[TRIPLE_END + arg % 4] = 8'($urandom_range(1, 255));
            RK_SHORT: rpt_len = 1 + arg % (RPT_LEN - 1);
            RK_LONG: rpt_len = RPT_LEN + 1 + arg % 6;
            RK_TARGET: begin
                // spoil the target on a single byte only
                p = arg % RPT_LEN;
                case ((arg / RPT_LEN) % 3)
                    0:       rpt_lay[p] = 2'd0;
                    1:       rpt_slt[p] = 5'd0;
                    default: rpt_slt[p] = 5'($urandom_range(SLOT_LIMIT + 1, 31));
                endcase
            end
            RK_NOISE: begin
                rpt_len   = $urandom_range(1, 70);
                noise_lay = 2'($urandom_range(0, 3));
                noise_slt = 5'($urandom_range(0, 31));
                for (int i = 0; i < BUF_BYTES; i++) begin
                    rpt_lay[i] = noise_lay;
                    rpt_slt[i] = noise_slt;
                    if ($urandom_range(0, 15) == 0) begin
                        rpt_lay[i] = 2'($urandom_range(0, 3));
                        rpt_slt[i] = 5'($urandom_range(0, 31));
                    end
                end
            end
            default: ;
        endcase

        // Codes inside the count, bar the last one, must be non-zero and distinct:
        // a code that fails there is never banked and a later triple would
        // compare against a bank entry never written in this report.
        if (rpt_len > 6 && rpt_data[6] >= 8'd1 && rpt_data[6] <= MAX_KEYS) begin
            cnt = rpt_data[6];
            for (int i = 0; i < cnt - 1; i++) begin
                p = TRIPLE_START + 3 * i;
                while (code_taken(rpt_data[p], i))
                    rpt_data[p] = 8'($urandom_range(1, 255));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Input channel
    // ---------------------------------------------------------------------

    // Offer one item, with an optional idle burst first; predict once it is taken
    task automatic send_item(input logic [7:0] b, input logic [1:0] lay, input logic [4:0] slt,
                             input bit last);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_target_layer <= lay;
        i_target_slot  <= slt;
        i_last_byte    <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        take_byte(b, lay, slt, last);
        bytes_sent++;
    endtask

    task automatic run_report(input t_rpt_kind kind, input logic [1:0] lay,
                              input logic [4:0] slt, input int keys, input int arg,
                              input t_verdict_src pin);
        build_report(kind, lay, slt, keys, arg);
        verdict_pin = pin;
        for (int i = 0; i < rpt_len; i++)
            send_item(rpt_data[i], rpt_lay[i], rpt_slt[i], i == rpt_len - 1);
        reports_sent++;
    endtask

    // ---------------------------------------------------------------------
    // Output channel: stall in random bursts while idling is on
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 5);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted verdict with the oldest one owed
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected verdict %0b at %0t", o_report_ok, $realtime);
            end else begin
                want = verdict_q.pop_front();
                if (o_report_ok !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("verdict mismatch: expected %0b, got %0b at %0t",
                                 want, o_report_ok, $realtime);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    initial begin
        t_case      row;
        t_rpt_kind  kind;
        logic [1:0] lay;
        logic [4:0] slt;
        int         roll;

        clear_report_state();
        for (int i = 0; i < MAX_KEYS; i++)
            bank_r[i] = 8'h00;
        bytes_sent   = 0;
        reports_sent = 0;
        gaps_on      = 1'b0;
        stall_left   = 0;
        mismatches   = 0;

        // hold reset, then release it for good
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[n]) begin
            row     = DIRECTED[n];
            gaps_on = $urandom_range(0, 3) != 0;
            run_report(row.kind, row.lay, row.slt, int'(row.keys), int'(row.arg), row.pin);
        end

        // Random part: a random mix of mostly well-formed reports with random
        // content, single-flaw reports and raw noise. Fill up the item budget of the
        // whole run; drop idling towards the end.
        reports_sent = 0;
        while (bytes_sent < TOTAL_BYTES || reports_sent < MIN_RANDOM_REPORTS) begin
            gaps_on = (bytes_sent < TOTAL_BYTES - QUIET_BYTES) && $urandom_range(0, 3) != 0;
            roll = $urandom_range(0, 99);
            if (roll < 55)
                kind = RK_GOOD;
            else if (roll < 60)
                kind = $urandom_range(0, 1) ? RK_ALL_MODS : RK_ZERO_SOLE;
            else if (roll < 88)
                kind = t_rpt_kind'($urandom_range(RK_HEADER, RK_TARGET));
            else
                kind = RK_NOISE;
            lay = 2'($urandom_range(1, 3));
            slt = 5'($urandom_range(1, SLOT_LIMIT));
            if ($urandom_range(0, 9) == 0) begin
                lay = 2'($urandom_range(0, 3));
                slt = 5'($urandom_range(0, 31));
            end
            run_report(kind, lay, slt, 0, $urandom_range(0, 255), V_PREDICT);
        end
        gaps_on = 1'b0;
        i_in_valid <= 1'b0;

        // drain the owed verdicts, then watch a little longer for strays
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
